// File: rtl/rrws_pkg.sv
// Package with the shared constants and types of the round-robin ready/wait scheduler.
`default_nettype none

package rrws_pkg;

  // Capacity of the ready list and of the waiting list.
  localparam int unsigned MaxThreads = 16;
  // Bits that address one list entry.
  localparam int unsigned IdxW = $clog2(MaxThreads);
  // Bits of a list count, which can hold MaxThreads itself.
  localparam int unsigned CntW = $clog2(MaxThreads + 1);
  // Bits of the sum of both counts.
  localparam int unsigned SumW = CntW + 1;

  // Fixed field widths of the streams.
  localparam int unsigned TidW   = 4;
  localparam int unsigned BitsW  = 16;
  localparam int unsigned TotW   = 5;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [2:0] {
    CmdStart  = 3'd0,
    CmdYield  = 3'd1,
    CmdWait   = 3'd2,
    CmdExit   = 3'd3,
    CmdCreate = 3'd4,
    CmdPoll   = 3'd5
  } rrws_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROM,
    S_CMD,
    S_RDCUR,
    S_REMOVE,
    S_MOVE,
    S_OUTRD,
    S_OUT
  } rrws_state_e;

endpackage

`default_nettype wire

// File: rtl/round_robin_ready_wait_scheduler.sv
// Top level of the round-robin ready/wait thread scheduler.
`default_nettype none

// The scheduler keeps a ready list and a waiting list of thread ids in two
// small RAMs, plus a current slot into the ready list. Each input transfer is
// one scheduling event: first every waiting thread whose data_ready bit is set
// moves to the ready tail in order and the waiting list is compacted, then the
// command (start, yield, wait for read, exit, create, poll) is applied, and one
// result transfer reports the thread to run together with both list sizes.
// The block handles one event at a time. An event runs from its input transfer
// through the waiting scan, the command step and the output read until its
// result is registered: the waiting scan reads one entry per cycle through the
// single read port of the waiting RAM, and a wait or exit adds read-modify-write
// steps on the ready RAM. A result that is still held in a full output register
// delays the load of the next result until the older one is taken. The next
// input is accepted as soon as the result is registered, even while that result
// still waits to be taken downstream. The list RAMs need no initialization after
// reset; only the counts, the slot, the scan registers, the state and the output
// valid flag are reset.

module round_robin_ready_wait_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0 up: thread_id[3:0], data_ready[19:4], zero pad [23:20].
  input  wire logic [23:0] s_axis_tdata,
  // Fields from bit 0 up: cmd[2:0].
  input  wire logic [2:0]  s_axis_tuser,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0 up: run_valid[0], run_thread[4:1], ready_total[9:5],
  // waiting_total[14:10], all_finished[15].
  output logic      [15:0] m_axis_tdata
);

  localparam int unsigned IdxW = rrws_pkg::IdxW;
  localparam int unsigned CntW = rrws_pkg::CntW;
  localparam int unsigned SumW = rrws_pkg::SumW;
  localparam int unsigned TidW = rrws_pkg::TidW;
  localparam int unsigned TotW = rrws_pkg::TotW;

  // Sequencer and bookkeeping registers.
  rrws_pkg::rrws_state_e state_q, state_d;
  logic [CntW-1:0] ready_cnt_q, ready_cnt_d;
  logic [CntW-1:0] wait_cnt_q, wait_cnt_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic            pend_q, pend_d;

  // The event being worked on.
  rrws_pkg::rrws_cmd_e     cmd_q;
  logic [TidW-1:0]         tid_q;
  logic [rrws_pkg::BitsW-1:0] bits_q;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  logic [rrws_pkg::OutDataW-1:0]  out_data_q, out_data_d;
  logic                           out_load;

  // Ready list RAM ports.
  logic            rl_we, rl_re;
  logic [IdxW-1:0] rl_waddr, rl_raddr;
  logic [TidW-1:0] rl_wdata, rl_rdata;

  // Waiting list RAM ports.
  logic            wl_we, wl_re;
  logic [IdxW-1:0] wl_waddr, wl_raddr;
  logic [TidW-1:0] wl_wdata, wl_rdata;

  logic            in_xfer;
  logic [IdxW-1:0] slot_c;
  logic [CntW-1:0] last_c;
  logic [SumW-1:0] total_c;
  logic            run_valid_c;

  assign s_axis_tready = (state_q == rrws_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Slot after the out-of-range fix-up, the index of the last ready entry and
  // the number of threads in both lists.
  assign slot_c  = (CntW'(slot_q) >= ready_cnt_q) ? '0 : slot_q;
  assign last_c  = ready_cnt_q - 1'b1;
  assign total_c = SumW'(ready_cnt_q) + SumW'(wait_cnt_q);
  assign run_valid_c = (ready_cnt_q != '0);

  rrws_ram #(
    .Depth(rrws_pkg::MaxThreads),
    .Width(TidW)
  ) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (rl_we),
    .waddr_i(rl_waddr),
    .wdata_i(rl_wdata),
    .re_i   (rl_re),
    .raddr_i(rl_raddr),
    .rdata_o(rl_rdata)
  );

  rrws_ram #(
    .Depth(rrws_pkg::MaxThreads),
    .Width(TidW)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (wl_we),
    .waddr_i(wl_waddr),
    .wdata_i(wl_wdata),
    .re_i   (wl_re),
    .raddr_i(wl_raddr),
    .rdata_o(wl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrws_pkg::S_IDLE;
      ready_cnt_q <= '0;
      wait_cnt_q  <= '0;
      slot_q      <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_cnt_q <= ready_cnt_d;
      wait_cnt_q  <= wait_cnt_d;
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Event fields and result payload need no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= rrws_pkg::rrws_cmd_e'(s_axis_tuser);
      tid_q  <= s_axis_tdata[3:0];
      bits_q <= s_axis_tdata[19:4];
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ready_cnt_d = ready_cnt_q;
    wait_cnt_d  = wait_cnt_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    pend_d      = pend_q;
    out_load    = 1'b0;
    rl_we       = 1'b0;
    rl_waddr    = ready_cnt_q[IdxW-1:0];
    rl_wdata    = wl_rdata;
    rl_re       = 1'b0;
    rl_raddr    = slot_q;
    wl_we       = 1'b0;
    wl_waddr    = kept_q[IdxW-1:0];
    wl_wdata    = wl_rdata;
    wl_re       = 1'b0;
    wl_raddr    = idx_q[IdxW-1:0];
    out_data_d  = {(total_c == '0), TotW'(wait_cnt_q), TotW'(ready_cnt_q),
                   (run_valid_c ? rl_rdata : {TidW{1'b0}}), run_valid_c};

    unique case (state_q)
      rrws_pkg::S_IDLE: begin
        if (in_xfer) begin
          idx_d   = '0;
          kept_d  = '0;
          pend_d  = 1'b0;
          state_d = rrws_pkg::S_PROM;
        end
      end

      // Waiting scan: the read of entry idx overlaps the handling of the entry
      // read just before it. Kept entries are written back at or below the
      // entry just handled, so a write never hits an entry still to be read.
      rrws_pkg::S_PROM: begin
        if (pend_q) begin
          if (bits_q[wl_rdata] && (ready_cnt_q < CntW'(rrws_pkg::MaxThreads))) begin
            rl_we       = 1'b1;
            rl_waddr    = ready_cnt_q[IdxW-1:0];
            rl_wdata    = wl_rdata;
            ready_cnt_d = ready_cnt_q + 1'b1;
          end else begin
            wl_we    = 1'b1;
            wl_waddr = kept_q[IdxW-1:0];
            wl_wdata = wl_rdata;
            kept_d   = kept_q + 1'b1;
          end
        end
        if (idx_q < wait_cnt_q) begin
          wl_re    = 1'b1;
          wl_raddr = idx_q[IdxW-1:0];
          idx_d    = idx_q + 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d     = 1'b0;
          wait_cnt_d = kept_d;
          state_d    = rrws_pkg::S_CMD;
        end
      end

      rrws_pkg::S_CMD: begin
        slot_d  = slot_c;
        state_d = rrws_pkg::S_OUTRD;
        case (cmd_q)
          rrws_pkg::CmdStart: begin
            slot_d = '0;
          end
          rrws_pkg::CmdYield: begin
            if ((CntW'(slot_c) + 1'b1) >= ready_cnt_q) begin
              slot_d = '0;
            end else begin
              slot_d = slot_c + 1'b1;
            end
          end
          rrws_pkg::CmdWait: begin
            if (run_valid_c) begin
              rl_re    = 1'b1;
              rl_raddr = slot_c;
              state_d  = rrws_pkg::S_RDCUR;
            end
          end
          rrws_pkg::CmdExit: begin
            if (run_valid_c) begin
              state_d = rrws_pkg::S_REMOVE;
            end
          end
          rrws_pkg::CmdCreate: begin
            if ((total_c < SumW'(rrws_pkg::MaxThreads))
                && (ready_cnt_q < CntW'(rrws_pkg::MaxThreads))) begin
              rl_we       = 1'b1;
              rl_waddr    = ready_cnt_q[IdxW-1:0];
              rl_wdata    = tid_q;
              ready_cnt_d = ready_cnt_q + 1'b1;
            end
          end
          default: begin
            // Poll and the unused codes only run the waiting scan and the slot fix-up.
          end
        endcase
      end

      // The current thread has been read: it goes to the waiting tail.
      rrws_pkg::S_RDCUR: begin
        if (wait_cnt_q < CntW'(rrws_pkg::MaxThreads)) begin
          wl_we      = 1'b1;
          wl_waddr   = wait_cnt_q[IdxW-1:0];
          wl_wdata   = rl_rdata;
          wait_cnt_d = wait_cnt_q + 1'b1;
        end
        state_d = rrws_pkg::S_REMOVE;
      end

      // Removal moves the last ready entry into the current slot, unless the
      // current slot is the last one, in which case the slot goes back to 0.
      rrws_pkg::S_REMOVE: begin
        if (CntW'(slot_q) != last_c) begin
          rl_re    = 1'b1;
          rl_raddr = last_c[IdxW-1:0];
          state_d  = rrws_pkg::S_MOVE;
        end else begin
          slot_d      = '0;
          ready_cnt_d = last_c;
          state_d     = rrws_pkg::S_OUTRD;
        end
      end

      rrws_pkg::S_MOVE: begin
        rl_we       = 1'b1;
        rl_waddr    = slot_q;
        rl_wdata    = rl_rdata;
        ready_cnt_d = last_c;
        state_d     = rrws_pkg::S_OUTRD;
      end

      // All writes of this event have landed, so the read sees final data.
      rrws_pkg::S_OUTRD: begin
        rl_re    = run_valid_c;
        rl_raddr = slot_q;
        state_d  = rrws_pkg::S_OUT;
      end

      rrws_pkg::S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = rrws_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rrws_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  // Between events both lists together never hold more than the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrws_pkg::S_IDLE) |-> (total_c <= SumW'(rrws_pkg::MaxThreads)))
    else $error("ready and waiting lists exceed capacity");

  // Between events the slot points into the ready list or is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrws_pkg::S_IDLE) |-> ((CntW'(slot_q) < ready_cnt_q) || (slot_q == '0)))
    else $error("current slot outside the ready list");

  // The scan never runs past the waiting count, and compaction never outruns it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrws_pkg::S_PROM) |-> ((idx_q <= wait_cnt_q) && (kept_q <= idx_q)))
    else $error("waiting scan index out of range");

  // A result is loaded only into a free or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// File: rtl/rrws_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module rrws_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 4,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
